// ===== hw/rtl/fefe_pkg.sv =====
package fefe_pkg;

    localparam logic [5:0] HEAT_MAX = 6'd36;

    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WB
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_status;

    function automatic logic [31:0] palette(input logic [5:0] h);
        logic [31:0] c;
        case (h)
            6'd0:  c = 32'h00000000;
            6'd1:  c = 32'h050000FF;
            6'd2:  c = 32'h0B0000FF;
            6'd3:  c = 32'h100000FF;
            6'd4:  c = 32'h180000FF;
            6'd5:  c = 32'h230000FF;
            6'd6:  c = 32'h2E0000FF;
            6'd7:  c = 32'h390000FF;
            6'd8:  c = 32'h490000FF;
            6'd9:  c = 32'h5A0000FF;
            6'd10: c = 32'h6A0000FF;
            6'd11: c = 32'h7B0100FF;
            6'd12: c = 32'h8C0600FF;
            6'd13: c = 32'h9C0C00FF;
            6'd14: c = 32'hAD1100FF;
            6'd15: c = 32'hBA1A00FF;
            6'd16: c = 32'hC52500FF;
            6'd17: c = 32'hD03000FF;
            6'd18: c = 32'hDC3C00FF;
            6'd19: c = 32'hE14C00FF;
            6'd20: c = 32'hE75D00FF;
            6'd21: c = 32'hEC6D00FF;
            6'd22: c = 32'hF17E00FF;
            6'd23: c = 32'hF58F00FF;
            6'd24: c = 32'hFAA000FF;
            6'd25: c = 32'hFEB000FF;
            6'd26: c = 32'hFFBC0DFF;
            6'd27: c = 32'hFFC81EFF;
            6'd28: c = 32'hFFD32EFF;
            6'd29: c = 32'hFFDD41FF;
            6'd30: c = 32'hFFE45DFF;
            6'd31: c = 32'hFFEB79FF;
            6'd32: c = 32'hFFF294FF;
            6'd33: c = 32'hFFF6AAFF;
            6'd34: c = 32'hFFF9BAFF;
            6'd35: c = 32'hFFFCCBFF;
            6'd36: c = 32'hFFFFDCFF;
            default: c = 32'hFFFFDCFF;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/fire_effect_frame_engine.sv =====
// The item's operands and heat-memory read are registered on acceptance; in
// S_WB the result is registered onto o_valid once the output is free, and
// any heat write of an advance item happens then. No new item is taken until
// S_WB ends, so a result held by i_stall holds off the next item's write-back.
// Reset: a clearing pass writes all FRAME_WIDTH*FRAME_HEIGHT cells (2048 by
// default), loading bottom row 36 and the rest 0; o_stall is high throughout.
module fire_effect_frame_engine #(
    parameter int FRAME_WIDTH  = 64,
    parameter int FRAME_HEIGHT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [1:0]  i_rnd,
    input  logic [5:0]  i_seed_heat,
    input  logic [10:0] i_pixel_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_wrote,
    output logic [10:0] o_cell_index,
    output logic [5:0]  o_heat,
    output logic [31:0] o_colour,
    output logic        o_frame_done
);

    fefe_pkg::t_cmd    cmd;
    fefe_pkg::t_status sts;

    fefe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    fefe_dp #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_opcode),
        .i_rnd         (i_rnd),
        .i_seed_heat   (i_seed_heat),
        .i_pixel_index (i_pixel_index),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_wrote       (o_wrote),
        .o_cell_index  (o_cell_index),
        .o_heat        (o_heat),
        .o_colour      (o_colour),
        .o_frame_done  (o_frame_done)
    );

endmodule

// ===== hw/rtl/fefe_ctrl.sv =====
module fefe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output fefe_pkg::t_cmd    o_cmd,
    input  fefe_pkg::t_status i_sts
);

    fefe_pkg::t_state r_state;
    fefe_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fefe_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fefe_pkg::S_CLEAR: begin
                if (i_sts.clear_last) n_state = fefe_pkg::S_IDLE;
            end
            fefe_pkg::S_IDLE: begin
                if (i_valid) n_state = fefe_pkg::S_WB;
            end
            fefe_pkg::S_WB: begin
                if (i_sts.out_free) n_state = fefe_pkg::S_IDLE;
            end
            default: n_state = fefe_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            fefe_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            fefe_pkg::S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            fefe_pkg::S_WB: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/fefe_dp.sv =====
module fefe_dp #(
    parameter int FRAME_WIDTH  = 64,
    parameter int FRAME_HEIGHT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fefe_pkg::t_cmd    i_cmd,
    output fefe_pkg::t_status o_sts,
    input  logic              i_opcode,
    input  logic [1:0]        i_rnd,
    input  logic [5:0]        i_seed_heat,
    input  logic [10:0]       i_pixel_index,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_wrote,
    output logic [10:0]       o_cell_index,
    output logic [5:0]        o_heat,
    output logic [31:0]       o_colour,
    output logic              o_frame_done
);

    localparam int CELLS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] SEED_BASE = AW'(CELLS - FRAME_WIDTH);
    localparam logic [AW:0]   WIDTH_V   = (AW+1)'(FRAME_WIDTH);

    logic [5:0] mem [CELLS];

    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_step;
    logic          r_op;
    logic [1:0]    r_rnd;
    logic [5:0]    r_seed;
    logic [10:0]   r_pix;
    logic          r_pix_ok;
    logic [AW-1:0] r_k;
    logic          r_done;
    logic [5:0]    r_rd_data;

    logic          r_out_valid;
    logic          r_wrote;
    logic [10:0]   r_cell;
    logic [5:0]    r_heat;
    logic [31:0]   r_colour;
    logic          r_fdone;

    logic [AW+10:0] pix_ext;
    logic [AW-1:0]  rd_addr;
    logic           step_last;

    logic [AW:0]    k_plus1;
    logic [AW:0]    thr;
    logic [AW:0]    spread_dst;
    logic           is_seed;
    logic           wb_write;
    logic [AW-1:0]  wb_addr;
    logic [5:0]     wb_heat;
    logic [AW+10:0] wb_addr_ext;
    logic [10:0]    wb_cell;
    logic [5:0]     wb_out_heat;
    logic [31:0]    wb_colour;

    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [5:0]     mem_data;

    assign pix_ext   = (AW+11)'(i_pixel_index);
    assign rd_addr   = (i_opcode == fefe_pkg::OP_READ) ? pix_ext[AW-1:0] : r_step;
    assign step_last = (r_step == LAST_CELL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_step <= '0;
        end else begin
            if (i_cmd.clear) r_clr <= r_clr + 1'b1;
            if (i_cmd.accept && i_opcode == fefe_pkg::OP_ADVANCE) begin
                r_step <= step_last ? '0 : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= i_opcode;
            r_rnd     <= i_rnd;
            r_seed    <= i_seed_heat;
            r_pix     <= i_pixel_index;
            r_pix_ok  <= 32'(i_pixel_index) < CELLS;
            r_k       <= r_step;
            r_done    <= step_last && (i_opcode == fefe_pkg::OP_ADVANCE);
            r_rd_data <= mem[rd_addr];
        end
    end

    assign k_plus1    = {1'b0, r_k} + 1'b1;
    assign thr        = WIDTH_V + (AW+1)'(r_rnd);
    assign spread_dst = k_plus1 - thr;
    assign is_seed    = {1'b0, r_k} < WIDTH_V;

    always_comb begin
        wb_write    = 1'b0;
        wb_addr     = '0;
        wb_heat     = '0;
        wb_out_heat = '0;
        wb_colour   = '0;
        if (r_op == fefe_pkg::OP_READ) begin
            wb_out_heat = r_pix_ok ? r_rd_data : 6'd0;
            wb_colour   = r_pix_ok ? fefe_pkg::palette(r_rd_data) : 32'd0;
        end else if (is_seed) begin
            wb_write    = 1'b1;
            wb_addr     = SEED_BASE + r_k;
            wb_heat     = (r_seed > fefe_pkg::HEAT_MAX) ? fefe_pkg::HEAT_MAX : r_seed;
            wb_out_heat = wb_heat;
            wb_colour   = fefe_pkg::palette(wb_heat);
        end else if (k_plus1 >= thr) begin
            wb_write    = 1'b1;
            wb_addr     = spread_dst[AW-1:0];
            wb_heat     = (r_rd_data > {5'd0, r_rnd[0]}) ? r_rd_data - {5'd0, r_rnd[0]} : 6'd0;
            wb_out_heat = wb_heat;
            wb_colour   = fefe_pkg::palette(wb_heat);
        end
    end

    assign wb_addr_ext = (AW+11)'(wb_addr);
    always_comb begin
        if (r_op == fefe_pkg::OP_READ) begin
            wb_cell = r_pix;
        end else if (wb_write) begin
            wb_cell = wb_addr_ext[10:0];
        end else begin
            wb_cell = 11'd0;
        end
    end

    always_comb begin
        mem_we   = 1'b0;
        mem_addr = r_clr;
        mem_data = (r_clr >= SEED_BASE) ? fefe_pkg::HEAT_MAX : 6'd0;
        if (i_cmd.clear) begin
            mem_we = 1'b1;
        end else if (i_cmd.finish && wb_write) begin
            mem_we   = 1'b1;
            mem_addr = wb_addr;
            mem_data = wb_heat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_wrote  <= wb_write;
            r_cell   <= wb_cell;
            r_heat   <= wb_out_heat;
            r_colour <= wb_colour;
            r_fdone  <= r_done;
        end
    end

    assign o_sts.clear_last = (r_clr == LAST_CELL);
    assign o_sts.out_free   = !r_out_valid || !i_stall;

    assign o_valid      = r_out_valid;
    assign o_wrote      = r_wrote;
    assign o_cell_index = r_cell;
    assign o_heat       = r_heat;
    assign o_colour     = r_colour;
    assign o_frame_done = r_fdone;

endmodule
